/* src/rcr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants, types and tables of the ray-cast column renderer.
// ----------------------------------------------------------------------------
package rcr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 40;
    localparam int MAP_SIZE      = 16;
    localparam int MAX_DEPTH     = 16;
    localparam int FIELD_OF_VIEW = 128;

    // march length in 0.1 tile steps
    localparam int STEPS_MAX = 10 * MAX_DEPTH;
    localparam int STEP_W    = $clog2(STEPS_MAX + 1);

    // ray accumulator: 640 * position + direction * steps, one cell is 5 * 2^15
    localparam int ACC_W      = 25;
    localparam int CELL_SHIFT = 15;
    localparam int CELL_SPAN  = 163840;

    typedef enum logic [2:0] {
        REG_MAP_A   = 3'd0,
        REG_MAP_B   = 3'd1,
        REG_MAP_C   = 3'd2,
        REG_MAP_D   = 3'd3,
        REG_PLAYER_X = 3'd4,
        REG_PLAYER_Y = 3'd5,
        REG_HEADING = 3'd6
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MARCH,
        ST_VXX,
        ST_VYY,
        ST_DX,
        ST_DY,
        ST_DSUM,
        ST_EXX,
        ST_EYY,
        ST_EMAG,
        ST_CHK,
        ST_PWR,
        ST_CMP,
        ST_START,
        ST_EMIT
    } cast_state_t;

    // outcome of one cast, handed to the row emitter
    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic              blanked;
    } cast_result_t;

    typedef logic [14:0] qsin_table_t [0:255];

    // quarter-wave sine polynomial in Q16, result Q1.14
    function automatic logic [14:0] quarter_sine(int unsigned r);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] s;
        logic [63:0] v;
        t  = 64'(r) << 8;
        t2 = (t * t) >> 16;
        s  = 64'd307;
        s  = 64'd5223 - ((t2 * s) >> 16);
        s  = 64'd42334 - ((t2 * s) >> 16);
        s  = 64'd102944 - ((t2 * s) >> 16);
        v  = ((t * s) >> 16) >> 2;
        if (v > 64'd16384)
        begin
            v = 64'd16384;
        end
        return 15'(v);
    endfunction

    function automatic qsin_table_t qsin_build();
        qsin_table_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    localparam qsin_table_t QSIN     = qsin_build();
    localparam logic [14:0] QSIN_TOP = quarter_sine(256);

    // full-turn sine, 1024 steps per turn, Q1.14
    function automatic logic signed [15:0] sine_q14(logic [9:0] a);
        logic [8:0]  r;
        logic [14:0] v;
        r = {1'b0, a[7:0]};
        if (a[8])
        begin
            r = 9'd256 - r;
        end
        v = r[8] ? QSIN_TOP : QSIN[r[7:0]];
        return a[9] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

/* src/rcr_row_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_row_emit
// Walks the screen rows of one cast column and drives the shade output
// register: ceiling, distance-banded wall or floor gradient per row.
// ----------------------------------------------------------------------------
module rcr_row_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rcr_pkg::cast_result_t result,
    input  logic                  shade_stall,
    output logic                  shade_valid,
    output logic [5:0]            row,
    output logic [3:0]            shade_code,
    output logic [12:0]           wall_distance,
    output logic                  edge_blanked,
    output logic                  last_row,
    output logic                  busy
);

    localparam int H = rcr_pkg::SCREEN_HEIGHT;

    logic                      busy_reg, busy_next;
    logic [5:0]                y_reg, y_next;
    logic [rcr_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic                      blank_reg, blank_next;
    logic [3:0]                shade_reg, shade_next;
    logic [12:0]               dist_reg, dist_next;

    logic        valid_reg, valid_next;
    logic [5:0]  row_reg, row_next;
    logic [3:0]  code_reg, code_next;
    logic [12:0] odist_reg, odist_next;
    logic        oblank_reg, oblank_next;
    logic        last_reg, last_next;

    logic [15:0]        dist_num;
    logic [31:0]        dist_prod;
    logic [3:0]         col_shade;
    logic signed [17:0] num;
    logic [8:0]         two_n;
    logic [6:0]         gap;
    logic [17:0]        ceil_prod;
    logic [17:0]        wall_prod;
    logic               is_ceil;
    logic               is_wall;
    logic [3:0]         row_code;
    logic               load;

    // distance and wall band of the column
    always_comb
    begin
        dist_num  = 16'({result.steps, 8'd0}) + 16'd5;
        dist_prod = 32'(dist_num) * 32'd52429;
        if (4 * int'(result.steps) <= rcr_pkg::STEPS_MAX)
            col_shade = 4'd1;
        else if (3 * int'(result.steps) < rcr_pkg::STEPS_MAX)
            col_shade = 4'd2;
        else if (2 * int'(result.steps) < rcr_pkg::STEPS_MAX)
            col_shade = 4'd3;
        else if (int'(result.steps) < rcr_pkg::STEPS_MAX)
            col_shade = 4'd4;
        else
            col_shade = 4'd0;
        if (result.blanked)
        begin
            col_shade = 4'd0;
        end
    end

    // classify the current row against the ceiling and floor lines
    always_comb
    begin
        num       = 18'(H * int'(steps_reg) - 20 * H);
        two_n     = {steps_reg, 1'b0};
        gap       = 7'(H - int'(y_reg));
        ceil_prod = 18'(two_n) * 18'(y_reg);
        wall_prod = 18'(two_n) * 18'(gap + 7'd1);
        is_ceil   = ($signed(ceil_prod) <= num)
                    || ((y_reg == 6'd0) && (num > -$signed(18'(two_n))));
        is_wall   = num < $signed(wall_prod);
        if (is_ceil)
            row_code = 4'd0;
        else if (is_wall)
            row_code = shade_reg;
        else if (8 * int'(gap) < H)
            row_code = 4'd5;
        else if (4 * int'(gap) < H)
            row_code = 4'd6;
        else if (8 * int'(gap) < 3 * H)
            row_code = 4'd7;
        else if (20 * int'(gap) < 9 * H)
            row_code = 4'd8;
        else
            row_code = 4'd0;
    end

    // advance rows while the output register can take one
    always_comb
    begin
        busy_next   = busy_reg;
        y_next      = y_reg;
        steps_next  = steps_reg;
        blank_next  = blank_reg;
        shade_next  = shade_reg;
        dist_next   = dist_reg;
        valid_next  = valid_reg && shade_stall;
        row_next    = row_reg;
        code_next   = code_reg;
        odist_next  = odist_reg;
        oblank_next = oblank_reg;
        last_next   = last_reg;
        load        = busy_reg && (!valid_reg || !shade_stall);
        if (start)
        begin
            busy_next  = 1'b1;
            y_next     = 6'd0;
            steps_next = result.steps;
            blank_next = result.blanked;
            shade_next = col_shade;
            dist_next  = dist_prod[31:19];
        end
        else if (load)
        begin
            valid_next  = 1'b1;
            row_next    = y_reg;
            code_next   = row_code;
            odist_next  = dist_reg;
            oblank_next = blank_reg;
            last_next   = (int'(y_reg) == H - 1);
            y_next      = y_reg + 6'd1;
            if (int'(y_reg) == H - 1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        steps_reg  <= steps_next;
        blank_reg  <= blank_next;
        shade_reg  <= shade_next;
        dist_reg   <= dist_next;
        row_reg    <= row_next;
        code_reg   <= code_next;
        odist_reg  <= odist_next;
        oblank_reg <= oblank_next;
        last_reg   <= last_next;
    end

    assign shade_valid   = valid_reg;
    assign row           = row_reg;
    assign shade_code    = code_reg;
    assign wall_distance = odist_reg;
    assign edge_blanked  = oblank_reg;
    assign last_row      = last_reg;
    assign busy          = busy_reg;

endmodule

/* src/raycast_column_renderer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_renderer
// Fixed-step grid ray caster: one screen column in, one shade code per row out.
// ----------------------------------------------------------------------------
// Each column request marches a ray one 0.1-tile step per clock, and the march
// ends at a depth of 16 tiles at most. A wall hit adds a corner test on one shared
// 32x32 multiplier (four products per corner, two for the ray magnitude, then
// a squared-dot and a magnitude product for each of the up to three nearest
// corners that face the ray). Then 40 rows leave at one per cycle while
// shade_stall is low, through an output register. A new column is not taken
// before the last row of the current one has been loaded: cast_stall stays
// high from acceptance until the row emitter has dropped busy and the
// sequencer has returned to idle.
module raycast_column_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        cast_valid,
    output logic        cast_stall,
    input  logic [6:0]  column,
    output logic        shade_valid,
    input  logic        shade_stall,
    output logic [5:0]  row,
    output logic [3:0]  shade_code,
    output logic [12:0] wall_distance,
    output logic        edge_blanked,
    output logic        last_row
);

    localparam int SW = rcr_pkg::STEP_W;
    localparam int AW = rcr_pkg::ACC_W;

    // configuration registers
    logic [63:0] map_reg [4];
    logic [11:0] player_x_reg;
    logic [11:0] player_y_reg;
    logic [9:0]  heading_reg;

    rcr_pkg::cast_state_t state_reg, state_next;
    logic [9:0]           angle_reg, angle_next;
    logic signed [15:0]   ex_reg, ex_next;
    logic signed [15:0]   ey_reg, ey_next;
    logic signed [AW-1:0] accx_reg, accx_next;
    logic signed [AW-1:0] accy_reg, accy_next;
    logic [SW-1:0]        n_reg, n_next;
    logic [SW-1:0]        steps_reg, steps_next;
    logic [3:0]           cx_reg, cx_next;
    logic [3:0]           cy_reg, cy_next;
    logic [1:0]           k_reg, k_next;
    logic [1:0]           drop_reg, drop_next;
    logic [25:0]          maxmag_reg, maxmag_next;
    logic [25:0]          mag_reg [4];
    logic [25:0]          mag_next [4];
    logic signed [28:0]   dot_reg [4];
    logic signed [28:0]   dot_next [4];
    logic [29:0]          emag_reg, emag_next;
    logic signed [63:0]   tmp_reg, tmp_next;
    logic signed [63:0]   prod_reg;
    logic                 blank_reg, blank_next;

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               accept;
    logic               emit_start;
    logic               emit_busy;
    logic [21:0]        q0x;
    logic [21:0]        q0y;
    logic               inx, iny;
    logic [3:0]         cellx, celly;
    logic               wall_hit;
    logic [63:0]        wall_word;
    logic [4:0]         cxk, cyk;
    logic signed [13:0] vx, vy;
    logic signed [63:0] sum64;
    logic [63:0]        diff;
    logic [69:0]        limit;

    rcr_pkg::cast_result_t result;

    // cell index of one axis: truncating divide by 5 * 2^15
    function automatic logic [4:0] cell_of(logic signed [AW-1:0] acc);
        logic [8:0]  hi;
        logic [18:0] q;
        logic        ok;
        logic [3:0]  idx;
        if (acc < 0)
        begin
            ok  = acc > -$signed(AW'(rcr_pkg::CELL_SPAN));
            idx = 4'd0;
        end
        else
        begin
            hi  = acc[rcr_pkg::CELL_SHIFT+8:rcr_pkg::CELL_SHIFT];
            q   = (19'(hi) * 19'd205) >> 10;
            ok  = int'(q) < rcr_pkg::MAP_SIZE;
            idx = q[3:0];
        end
        return {ok, idx};
    endfunction

    assign accept     = cast_valid && !cast_stall;
    assign cast_stall = (state_reg != rcr_pkg::ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                map_reg[i] <= 64'd0;
            end
            player_x_reg <= 12'd2048;
            player_y_reg <= 12'd2048;
            heading_reg  <= 10'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rcr_pkg::cfg_index_t'(cfg_index))
                rcr_pkg::REG_MAP_A:    map_reg[0]   <= cfg_wdata;
                rcr_pkg::REG_MAP_B:    map_reg[1]   <= cfg_wdata;
                rcr_pkg::REG_MAP_C:    map_reg[2]   <= cfg_wdata;
                rcr_pkg::REG_MAP_D:    map_reg[3]   <= cfg_wdata;
                rcr_pkg::REG_PLAYER_X: player_x_reg <= cfg_wdata[11:0];
                rcr_pkg::REG_PLAYER_Y: player_y_reg <= cfg_wdata[11:0];
                rcr_pkg::REG_HEADING:  heading_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // march cell lookup
    always_comb
    begin
        q0x             = 22'(player_x_reg) * 22'd640;
        q0y             = 22'(player_y_reg) * 22'd640;
        {inx, cellx}    = cell_of(accx_reg);
        {iny, celly}    = cell_of(accy_reg);
        wall_word       = map_reg[cellx[3:2]];
        wall_hit        = wall_word[{cellx[1:0], celly}];
        cxk             = 5'(cx_reg) + 5'(k_reg[1]);
        cyk             = 5'(cy_reg) + 5'(k_reg[0]);
        vx              = $signed({1'b0, cxk, 8'd0}) - $signed({2'b0, player_x_reg});
        vy              = $signed({1'b0, cyk, 8'd0}) - $signed({2'b0, player_y_reg});
        sum64           = tmp_reg + prod_reg;
        diff            = 64'(prod_reg - tmp_reg);
        limit           = (70'(diff) + 70'd1) * 70'd10000;
    end

    // sequencer: next state, multiplier operands and datapath updates
    always_comb
    begin
        state_next  = state_reg;
        angle_next  = angle_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        accx_next   = accx_reg;
        accy_next   = accy_reg;
        n_next      = n_reg;
        steps_next  = steps_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        k_next      = k_reg;
        drop_next   = drop_reg;
        maxmag_next = maxmag_reg;
        mag_next    = mag_reg;
        dot_next    = dot_reg;
        emag_next   = emag_reg;
        tmp_next    = tmp_reg;
        blank_next  = blank_reg;
        mul_a       = 32'sd0;
        mul_b       = 32'sd0;
        emit_start  = 1'b0;

        unique case (state_reg)
            rcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    angle_next = heading_reg
                                 + 10'(1024 - rcr_pkg::FIELD_OF_VIEW / 2)
                                 + 10'((int'(column) * rcr_pkg::FIELD_OF_VIEW)
                                       / rcr_pkg::SCREEN_WIDTH);
                    state_next = rcr_pkg::ST_INIT;
                end
            end
            rcr_pkg::ST_INIT:
            begin
                ex_next    = rcr_pkg::sine_q14(angle_reg);
                ey_next    = rcr_pkg::sine_q14(angle_reg + 10'd256);
                accx_next  = $signed(AW'(q0x)) + AW'(ex_next);
                accy_next  = $signed(AW'(q0y)) + AW'(ey_next);
                n_next     = SW'(1);
                blank_next = 1'b0;
                state_next = rcr_pkg::ST_MARCH;
            end
            rcr_pkg::ST_MARCH:
            begin
                if (!(inx && iny))
                begin
                    steps_next = SW'(rcr_pkg::STEPS_MAX);
                    state_next = rcr_pkg::ST_START;
                end
                else if (wall_hit)
                begin
                    steps_next = n_reg;
                    cx_next    = cellx;
                    cy_next    = celly;
                    k_next     = 2'd0;
                    state_next = rcr_pkg::ST_VXX;
                end
                else if (int'(n_reg) == rcr_pkg::STEPS_MAX)
                begin
                    steps_next = SW'(rcr_pkg::STEPS_MAX);
                    state_next = rcr_pkg::ST_START;
                end
                else
                begin
                    accx_next = accx_reg + AW'(ex_reg);
                    accy_next = accy_reg + AW'(ey_reg);
                    n_next    = n_reg + SW'(1);
                end
            end
            rcr_pkg::ST_VXX:
            begin
                mul_a      = 32'(vx);
                mul_b      = 32'(vx);
                state_next = rcr_pkg::ST_VYY;
            end
            rcr_pkg::ST_VYY:
            begin
                mul_a      = 32'(vy);
                mul_b      = 32'(vy);
                tmp_next   = prod_reg;
                state_next = rcr_pkg::ST_DX;
            end
            rcr_pkg::ST_DX:
            begin
                mul_a            = 32'(ex_reg);
                mul_b            = 32'(vx);
                mag_next[k_reg]  = sum64[25:0];
                // keep the farthest corner, the last one on ties
                if ((k_reg == 2'd0) || (sum64[25:0] >= maxmag_reg))
                begin
                    drop_next   = k_reg;
                    maxmag_next = sum64[25:0];
                end
                state_next = rcr_pkg::ST_DY;
            end
            rcr_pkg::ST_DY:
            begin
                mul_a      = 32'(ey_reg);
                mul_b      = 32'(vy);
                tmp_next   = prod_reg;
                state_next = rcr_pkg::ST_DSUM;
            end
            rcr_pkg::ST_DSUM:
            begin
                dot_next[k_reg] = sum64[28:0];
                k_next          = k_reg + 2'd1;
                state_next      = (k_reg == 2'd3) ? rcr_pkg::ST_EXX : rcr_pkg::ST_VXX;
            end
            rcr_pkg::ST_EXX:
            begin
                mul_a      = 32'(ex_reg);
                mul_b      = 32'(ex_reg);
                state_next = rcr_pkg::ST_EYY;
            end
            rcr_pkg::ST_EYY:
            begin
                mul_a      = 32'(ey_reg);
                mul_b      = 32'(ey_reg);
                tmp_next   = prod_reg;
                state_next = rcr_pkg::ST_EMAG;
            end
            rcr_pkg::ST_EMAG:
            begin
                emag_next  = sum64[29:0];
                k_next     = 2'd0;
                state_next = rcr_pkg::ST_CHK;
            end
            rcr_pkg::ST_CHK:
            begin
                if ((k_reg != drop_reg) && (dot_reg[k_reg] > 29'sd0))
                begin
                    mul_a      = 32'(dot_reg[k_reg]);
                    mul_b      = 32'(dot_reg[k_reg]);
                    state_next = rcr_pkg::ST_PWR;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = (k_reg == 2'd3) ? rcr_pkg::ST_START : rcr_pkg::ST_CHK;
                end
            end
            rcr_pkg::ST_PWR:
            begin
                mul_a      = $signed({2'b0, emag_reg});
                mul_b      = $signed({6'b0, mag_reg[k_reg]});
                tmp_next   = prod_reg;
                state_next = rcr_pkg::ST_CMP;
            end
            rcr_pkg::ST_CMP:
            begin
                // dot^2 > P - P/10000  <=>  P < dot^2  or  P >= 10000 * (P - dot^2 + 1)
                if (tmp_reg > prod_reg)
                begin
                    blank_next = 1'b1;
                end
                else if (70'($unsigned(prod_reg)) >= limit)
                begin
                    blank_next = 1'b1;
                end
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? rcr_pkg::ST_START : rcr_pkg::ST_CHK;
            end
            rcr_pkg::ST_START:
            begin
                emit_start = 1'b1;
                state_next = rcr_pkg::ST_EMIT;
            end
            rcr_pkg::ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = rcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers and the shared multiplier
    always_ff @(posedge clk)
    begin
        angle_reg  <= angle_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        accx_reg   <= accx_next;
        accy_reg   <= accy_next;
        n_reg      <= n_next;
        steps_reg  <= steps_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        k_reg      <= k_next;
        drop_reg   <= drop_next;
        maxmag_reg <= maxmag_next;
        mag_reg    <= mag_next;
        dot_reg    <= dot_next;
        emag_reg   <= emag_next;
        tmp_reg    <= tmp_next;
        blank_reg  <= blank_next;
        prod_reg   <= mul_a * mul_b;
    end

    assign result.steps   = steps_reg;
    assign result.blanked = blank_reg;

    rcr_row_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (emit_start),
        .result        (result),
        .shade_stall   (shade_stall),
        .shade_valid   (shade_valid),
        .row           (row),
        .shade_code    (shade_code),
        .wall_distance (wall_distance),
        .edge_blanked  (edge_blanked),
        .last_row      (last_row),
        .busy          (emit_busy)
    );

endmodule

/* src/rcr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_checker
// Port-level checks of the ray-cast column renderer, bound to the top level.
// ----------------------------------------------------------------------------
module rcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cast_valid,
    input logic        cast_stall,
    input logic        shade_valid,
    input logic        shade_stall,
    input logic [5:0]  row,
    input logic [3:0]  shade_code,
    input logic [12:0] wall_distance,
    input logic        edge_blanked,
    input logic        last_row
);

    // hold a stalled request
    assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && shade_stall |=> shade_valid && $stable(row) && $stable(shade_code))
        else $error("stalled shade request changed");

    // busy right after taking a column
    assert property (@(posedge clk) disable iff (!rst_n)
        cast_valid && !cast_stall |=> cast_stall)
        else $error("column accepted while idle did not raise stall");

    // final row flag matches the screen height
    assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && last_row |-> (row == 6'(rcr_pkg::SCREEN_HEIGHT - 1)))
        else $error("last_row on wrong row");

    // blanked wall never shows a wall shade
    assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid && edge_blanked |->
            !(shade_code == 4'd1 || shade_code == 4'd2
              || shade_code == 4'd3 || shade_code == 4'd4))
        else $error("blanked column shows wall shade");

    // distance never beyond depth
    assert property (@(posedge clk) disable iff (!rst_n)
        shade_valid |-> (int'(wall_distance) <= rcr_pkg::MAX_DEPTH * 256))
        else $error("wall distance beyond depth");

endmodule

bind raycast_column_renderer rcr_checker u_rcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cast_valid    (cast_valid),
    .cast_stall    (cast_stall),
    .shade_valid   (shade_valid),
    .shade_stall   (shade_stall),
    .row           (row),
    .shade_code    (shade_code),
    .wall_distance (wall_distance),
    .edge_blanked  (edge_blanked),
    .last_row      (last_row)
);

/* dv/raycast_column_renderer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raycast_column_renderer_test
// Self-checking bench for the ray-cast column renderer.
// ----------------------------------------------------------------------------
// A driver sends column requests from a queue of pending columns. Requests go
// out in bursts with random gaps. A monitor computes the expected shade rows
// for each accepted request from a local copy of the map and player registers,
// and then checks each returned row against the oldest expected row. The
// renderer is reconfigured only while it is idle, between phases of the run.
// ----------------------------------------------------------------------------
module raycast_column_renderer_test;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int CAST_STEPS = 10 * rcr_pkg::MAX_DEPTH;
    localparam longint CELL_DIV = 64'd41943040;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [5:0]  row;
        logic [3:0]  code;
        logic [12:0] wdist;
        logic        blanked;
        logic        last;
    } shade_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;
    logic        cast_valid;
    logic        cast_stall;
    logic [6:0]  column;
    logic        shade_valid;
    logic        shade_stall;
    logic [5:0]  row;
    logic [3:0]  shade_code;
    logic [12:0] wall_distance;
    logic        edge_blanked;
    logic        last_row;

    // shadow of the configuration registers
    logic [63:0] map_word [0:3];
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [9:0]  heading;

    logic [6:0]  pending_cols [$];
    shade_row_t  expected_rows [$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_left;
    bit          cast_taken;

    raycast_column_renderer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cast_valid    (cast_valid),
        .cast_stall    (cast_stall),
        .column        (column),
        .shade_valid   (shade_valid),
        .shade_stall   (shade_stall),
        .row           (row),
        .shade_code    (shade_code),
        .wall_distance (wall_distance),
        .edge_blanked  (edge_blanked),
        .last_row      (last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // quarter-wave sine in Q1.14 from the Q16 polynomial
    function automatic longint quarter_wave(int unsigned r);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned s;
        longint unsigned v;
        t  = longint'(r) << 8;
        t2 = (t * t) >> 16;
        s  = 307;
        s  = 5223 - ((t2 * s) >> 16);
        s  = 42334 - ((t2 * s) >> 16);
        s  = 102944 - ((t2 * s) >> 16);
        v  = ((t * s) >> 16) >> 2;
        if (v > 16384)
        begin
            v = 16384;
        end
        return longint'(v);
    endfunction

    function automatic longint ray_sine(int unsigned a);
        int unsigned q;
        int unsigned r;
        longint      v;
        a = a & 1023;
        q = a >> 8;
        r = a & 255;
        if (q & 1)
        begin
            r = 256 - r;
        end
        v = quarter_wave(r);
        return (q & 2) ? -v : v;
    endfunction

    function automatic bit wall_at(longint r, longint c);
        logic [63:0] w;
        w = map_word[(r >> 2) & 3];
        return w[((r & 3) * 16 + c) & 63];
    endfunction

    // blank when the ray points within the corner tolerance of a near corner
    function automatic bit near_corner(longint cx, longint cy, longint ex, longint ey);
        longint          dot [4];
        longint unsigned mag [4];
        longint unsigned emag;
        longint unsigned d2;
        longint unsigned p;
        longint          vx;
        longint          vy;
        int              far_k;
        bit              hit;
        emag  = ex * ex + ey * ey;
        far_k = 0;
        hit   = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            vx = (cx + (k >> 1)) * 256 - longint'(pos_x);
            vy = (cy + (k & 1)) * 256 - longint'(pos_y);
            mag[k] = vx * vx + vy * vy;
            dot[k] = ex * vx + ey * vy;
            if (mag[k] >= mag[far_k])
            begin
                far_k = k;
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            if (k != far_k && dot[k] > 0)
            begin
                d2 = longint'(dot[k]) * longint'(dot[k]);
                p  = emag * mag[k];
                if (d2 > p - p / 10000)
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // march one column and queue its shade rows
    task automatic render_column(logic [6:0] col);
        int unsigned ang;
        longint      ex;
        longint      ey;
        longint      cx;
        longint      cy;
        int          steps;
        bit          blank;
        int          shade;
        int          ceil_row;
        int          floor_row;
        int          gap;
        int          code;
        int          h;
        shade_row_t  r;
        h     = rcr_pkg::SCREEN_HEIGHT;
        ang   = (int'(heading) + 1024 - rcr_pkg::FIELD_OF_VIEW / 2
                 + (int'(col) * rcr_pkg::FIELD_OF_VIEW) / rcr_pkg::SCREEN_WIDTH) & 1023;
        ex    = ray_sine(ang);
        ey    = ray_sine(ang + 256);
        steps = CAST_STEPS;
        blank = 1'b0;
        for (int n = 1; n <= CAST_STEPS; n++)
        begin
            cx = (longint'(pos_x) * 163840 + ex * n * 256) / CELL_DIV;
            cy = (longint'(pos_y) * 163840 + ey * n * 256) / CELL_DIV;
            if (cx < 0 || cx >= rcr_pkg::MAP_SIZE || cy < 0 || cy >= rcr_pkg::MAP_SIZE)
            begin
                break;
            end
            if (wall_at(cx, cy))
            begin
                steps = n;
                blank = near_corner(cx, cy, ex, ey);
                break;
            end
        end
        if (4 * steps <= CAST_STEPS)      shade = 1;
        else if (3 * steps < CAST_STEPS)  shade = 2;
        else if (2 * steps < CAST_STEPS)  shade = 3;
        else if (steps < CAST_STEPS)      shade = 4;
        else                              shade = 0;
        if (blank)
        begin
            shade = 0;
        end
        ceil_row  = (h * steps - 20 * h) / (2 * steps);
        floor_row = h - ceil_row;
        for (int y = 0; y < h; y++)
        begin
            if (y <= ceil_row)
            begin
                code = 0;
            end
            else if (y <= floor_row)
            begin
                code = shade;
            end
            else
            begin
                gap = h - y;
                if (8 * gap < h)            code = 5;
                else if (4 * gap < h)       code = 6;
                else if (8 * gap < 3 * h)   code = 7;
                else if (20 * gap < 9 * h)  code = 8;
                else                        code = 0;
            end
            r.row     = 6'(y);
            r.code    = 4'(code);
            r.wdist   = 13'((steps * 256 + 5) / 10);
            r.blanked = blank;
            r.last    = (y == h - 1);
            expected_rows = {expected_rows, r};
        end
    endtask

    // drive requests in bursts with random gaps; hold a request until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cast_valid && !cast_taken)
            begin
                // hold
            end
            else
            begin
                cast_taken = 1'b0;
                if (pending_cols.size() > 0 && gap_left == 0)
                begin
                    cast_valid <= 1'b1;
                    column     <= pending_cols[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 6);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                    begin
                        burst_left = burst_left - 1;
                    end
                end
                else
                begin
                    cast_valid <= 1'b0;
                    if (gap_left > 0)
                    begin
                        gap_left = gap_left - 1;
                    end
                end
            end
        end
    end

    // stall the result side on its own pattern of modes
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 120);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0:       shade_stall <= 1'b0;
            1:       shade_stall <= ($urandom_range(0, 3) == 0);
            2:       shade_stall <= ($urandom_range(0, 1) == 0);
            default: shade_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // accept requests, predict rows, check returned rows
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (cast_valid && !cast_stall)
            begin
                idle_cycles = 0;
                cast_taken  = 1'b1;
                void'(pending_cols.pop_front());
                render_column(column);
            end
            if (shade_valid && !shade_stall)
            begin
                idle_cycles = 0;
                if (expected_rows.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected shade row %0d code %0d", row, shade_code);
                    end
                end
                else if (expected_rows[0].row != row || expected_rows[0].code != shade_code
                         || expected_rows[0].wdist != wall_distance
                         || expected_rows[0].blanked != edge_blanked
                         || expected_rows[0].last != last_row)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("row mismatch: exp row %0d code %0d dist %0d blank %0b last %0b",
                                 expected_rows[0].row, expected_rows[0].code,
                                 expected_rows[0].wdist, expected_rows[0].blanked,
                                 expected_rows[0].last);
                        $display("              got row %0d code %0d dist %0d blank %0b last %0b",
                                 row, shade_code, wall_distance, edge_blanked, last_row);
                    end
                    void'(expected_rows.pop_front());
                end
                else
                begin
                    void'(expected_rows.pop_front());
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rcr_pkg::REG_MAP_A:    map_word[0] = val;
            rcr_pkg::REG_MAP_B:    map_word[1] = val;
            rcr_pkg::REG_MAP_C:    map_word[2] = val;
            rcr_pkg::REG_MAP_D:    map_word[3] = val;
            rcr_pkg::REG_PLAYER_X: pos_x = val[11:0];
            rcr_pkg::REG_PLAYER_Y: pos_y = val[11:0];
            rcr_pkg::REG_HEADING:  heading = val[9:0];
            default:      ;
        endcase
    endtask

    task automatic configure(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d,
                             logic [63:0] px, logic [63:0] py, logic [63:0] hd);
        write_reg(rcr_pkg::REG_MAP_A, a);
        write_reg(rcr_pkg::REG_MAP_B, b);
        write_reg(rcr_pkg::REG_MAP_C, c);
        write_reg(rcr_pkg::REG_MAP_D, d);
        write_reg(rcr_pkg::REG_PLAYER_X, px);
        write_reg(rcr_pkg::REG_PLAYER_Y, py);
        write_reg(rcr_pkg::REG_HEADING, hd);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every pending request and expected row, then settle
    task automatic drain();
        wait (pending_cols.size() == 0 && expected_rows.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word(int density);
        logic [63:0] w;
        w = {$urandom, $urandom};
        for (int i = 0; i < density; i++)
        begin
            w = w & {$urandom, $urandom};
        end
        return w;
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            pending_cols = {pending_cols, (($urandom_range(0, 7) == 0) ?
                                           (($urandom_range(0, 1) == 0) ? 7'd0 : 7'd127) :
                                           7'($urandom_range(0, 127)))};
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = rcr_pkg::REG_MAP_A;
        cfg_wdata   = '0;
        cast_valid  = 1'b0;
        column      = '0;
        shade_stall = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 1;
        gap_left    = 0;
        stall_mode  = 0;
        stall_left  = 0;
        cast_taken  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            map_word[i] = '0;
        end
        pos_x   = 12'd2048;
        pos_y   = 12'd2048;
        heading = 10'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset map is empty: every ray leaves the map
        pending_cols = {pending_cols, 7'd0};
        pending_cols = {pending_cols, 7'd127};
        pending_cols = {pending_cols, 7'd64};
        drain();

        // walled border, extreme heading; unused index must be ignored
        configure(64'h8001_8001_8001_FFFF, 64'h8001_8001_8001_8001,
                  64'h8001_8001_8001_8001, 64'hFFFF_8001_8001_8001,
                  64'h0000_0000_0000_0880, 64'hFFFF_FFFF_FFFF_F7C0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        for (int c = 0; c < 128; c += 16)
        begin
            pending_cols = {pending_cols, 7'(c)};
        end
        pending_cols = {pending_cols, 7'd127};
        drain();

        // player inside a solid map: hit on the first step
        configure('1, '1, '1, '1, 64'd0, 64'd0, 64'd0);
        pending_cols = {pending_cols, 7'd0};
        pending_cols = {pending_cols, 7'd127};
        drain();

        // player at the far map corner, empty map, aimed out of it
        configure('0, '0, '0, '0, 64'hFFF, 64'hFFF, 64'd512);
        pending_cols = {pending_cols, 7'd0};
        pending_cols = {pending_cols, 7'd63};
        drain();

        // a lone pillar for corner-aligned rays
        configure(64'd0, 64'h0000_0000_0100_0000, 64'd0, 64'd0, 64'd1024, 64'd1024, 64'd128);
        for (int c = 50; c < 80; c += 5)
        begin
            pending_cols = {pending_cols, 7'(c)};
        end
        drain();

        // random maps, positions and headings
        for (int ph = 0; ph < 9; ph++)
        begin
            configure(rand_word(ph % 3), rand_word(ph % 3), rand_word(ph % 3), rand_word(ph % 3),
                      64'($urandom_range(0, 4095)), 64'($urandom_range(0, 4095)),
                      64'($urandom_range(0, 1023)));
            queue_random(23);
            drain();
        end

        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rcr_pkg.sv
src/rcr_row_emit.sv
src/raycast_column_renderer.sv
src/rcr_checker.sv
dv/raycast_column_renderer_test.sv
